// ===== hw/rtl/msq_pkg.sv =====
// msq_pkg: shared types, constants and case tables of the marching squares cell segmenter
// no dependencies; used by msq_datapath, msq_ctrl and the top level

package msq_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 16;
    localparam int CFG_COLS_W = 11;
    localparam int ROW_W      = 16;
    localparam int COL_OUT_W  = 10;
    localparam int EDGE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

    localparam logic [EDGE_W-1:0] EDGE_TOP    = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [EDGE_W-1:0] EDGE_LEFT   = 2'd3;

    localparam logic [3:0] CASE_EMPTY   = 4'd0;
    localparam logic [3:0] CASE_SADDLE5 = 4'd5;
    localparam logic [3:0] CASE_SADDLE10 = 4'd10;
    localparam logic [3:0] CASE_FULL    = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLASS,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       capture;
        logic       classify;
        logic       prep;
        logic       store_q;
        logic       emit;
        logic [1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic has_seg;
        logic two_seg;
        logic direct;
        logic div_done;
        logic out_free;
    } t_sts;

    // edge pair of a single-segment case: {first, second}
    function automatic logic [2*EDGE_W-1:0] plain_pair(input logic [3:0] cs);
        logic [2*EDGE_W-1:0] p;
        case (cs)
            4'd1:    p = {EDGE_TOP, EDGE_LEFT};
            4'd2:    p = {EDGE_TOP, EDGE_RIGHT};
            4'd3:    p = {EDGE_LEFT, EDGE_RIGHT};
            4'd4:    p = {EDGE_RIGHT, EDGE_BOTTOM};
            4'd6:    p = {EDGE_TOP, EDGE_BOTTOM};
            4'd7:    p = {EDGE_BOTTOM, EDGE_LEFT};
            4'd8:    p = {EDGE_BOTTOM, EDGE_LEFT};
            4'd9:    p = {EDGE_TOP, EDGE_BOTTOM};
            4'd11:   p = {EDGE_RIGHT, EDGE_BOTTOM};
            4'd12:   p = {EDGE_LEFT, EDGE_RIGHT};
            4'd13:   p = {EDGE_TOP, EDGE_RIGHT};
            4'd14:   p = {EDGE_TOP, EDGE_LEFT};
            default: p = {EDGE_TOP, EDGE_TOP};
        endcase
        return p;
    endfunction

    function automatic logic is_plain(input logic [3:0] cs);
        return !(cs inside {CASE_EMPTY, CASE_SADDLE5, CASE_SADDLE10, CASE_FULL});
    endfunction

endpackage

// ===== hw/rtl/msq_div.sv =====
// msq_div: radix-2 restoring divider, one quotient bit per cycle
// computes (num << Q_W) / den for num < den; no package dependency

module msq_div #(
    parameter int NUM_W = 17,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   trial;
    logic             fits;

    assign shifted = {r_rem, 1'b0};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
            r_q   <= {r_q[Q_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/msq_datapath.sv =====
// msq_datapath: configuration registers, row store, corner registers, cell classification,
// crossing fraction setup with divider and output register; uses msq_pkg and msq_div

module msq_datapath #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [msq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  msq_pkg::t_cmd                       i_cmd,
    output msq_pkg::t_sts                       o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [msq_pkg::COL_OUT_W-1:0]       o_cell_column,
    output logic [msq_pkg::ROW_W-1:0]           o_cell_row,
    output logic [msq_pkg::EDGE_W-1:0]          o_first_edge,
    output logic [FRACTION_BITS:0]              o_first_fraction,
    output logic [msq_pkg::EDGE_W-1:0]          o_second_edge,
    output logic [FRACTION_BITS:0]              o_second_fraction,
    output logic                                o_last_of_cell
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = (COL_W + 1 > msq_pkg::CFG_COLS_W) ? COL_W + 1 : msq_pkg::CFG_COLS_W;
    localparam int MAG_W  = (SAMPLE_BITS > msq_pkg::THR_W) ? SAMPLE_BITS : msq_pkg::THR_W;
    localparam int DW     = MAG_W + 1;
    localparam int SUM_W  = DW + 2;
    localparam int FRAC_W = FRACTION_BITS + 1;
    localparam int ROW_W  = msq_pkg::ROW_W;
    localparam int EW     = msq_pkg::EDGE_W;
    localparam logic [FRAC_W-1:0] FRAC_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_ONE >> 1;

    // configuration
    logic signed [msq_pkg::THR_W-1:0]      r_thr;
    logic [msq_pkg::CFG_COLS_W-1:0]        r_cols_cfg;
    logic [ROW_W-1:0]                      r_rows_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= '0;
            r_cols_cfg <= msq_pkg::CFG_COLS_W'(2);
            r_rows_cfg <= ROW_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                msq_pkg::CFG_THRESHOLD: r_thr      <= i_cfg_data;
                msq_pkg::CFG_COLUMNS:   r_cols_cfg <= i_cfg_data[msq_pkg::CFG_COLS_W-1:0];
                msq_pkg::CFG_ROWS:      r_rows_cfg <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] cols_ext;
    logic [CNT_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_eff;

    assign cols_ext = CNT_W'(r_cols_cfg);
    assign cols_eff = (cols_ext < CNT_W'(2)) ? CNT_W'(2) :
                      (cols_ext > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_ext;
    assign rows_eff = (r_rows_cfg < ROW_W'(2)) ? ROW_W'(2) : r_rows_cfg;

    // position, row store and corners
    logic [COL_W-1:0]              r_col;
    logic [ROW_W-1:0]              r_row;
    logic [SAMPLE_BITS-1:0]        r_sample;
    logic [SAMPLE_BITS-1:0]        r_above;
    logic [SAMPLE_BITS-1:0]        r_ul;
    logic [SAMPLE_BITS-1:0]        r_ll;
    logic signed [SAMPLE_BITS-1:0] r_cor [4];
    logic                          r_cell;
    logic [COL_W-1:0]              r_cell_col;
    logic [ROW_W-1:0]              r_cell_row;
    logic [SAMPLE_BITS-1:0]        mem [MAX_COLUMNS];

    logic [CNT_W-1:0] col_inc;
    logic [ROW_W:0]   row_inc;

    assign col_inc = CNT_W'(r_col) + CNT_W'(1);
    assign row_inc = {1'b0, r_row} + {{ROW_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            mem[r_col] <= r_sample;
        end
        if (i_cmd.accept) begin
            r_above <= mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.capture) begin
            r_cor[0]   <= r_ul;
            r_cor[1]   <= r_above;
            r_cor[2]   <= r_sample;
            r_cor[3]   <= r_ll;
            r_cell_col <= r_col - 1'b1;
            r_cell_row <= r_row - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ul   <= '0;
            r_ll   <= '0;
            r_cell <= 1'b0;
        end else if (i_cmd.capture) begin
            r_ul   <= r_above;
            r_ll   <= r_sample;
            r_cell <= (r_col != '0) && (r_row != '0);
            if (col_inc >= cols_eff) begin
                r_col <= '0;
                r_row <= (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    // classification
    logic signed [DW-1:0]    cor_x [4];
    logic signed [DW-1:0]    thr_x;
    logic signed [SUM_W-1:0] corner_sum;
    logic signed [SUM_W-1:0] thr4;
    logic [3:0]              cs;
    logic                    saddle;
    logic                    tr_first;
    logic [2*EW-1:0]         pair;
    logic [EW-1:0]           r_edge [4];
    logic                    r_two;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cor_x[i] = DW'(r_cor[i]);
        end
    end

    assign thr_x      = DW'(r_thr);
    assign thr4       = SUM_W'(thr_x) <<< 2;
    assign corner_sum = SUM_W'(cor_x[0]) + SUM_W'(cor_x[1]) + SUM_W'(cor_x[2])
                      + SUM_W'(cor_x[3]);
    assign cs         = {cor_x[3] >= thr_x, cor_x[2] >= thr_x,
                         cor_x[1] >= thr_x, cor_x[0] >= thr_x};
    assign saddle     = (cs == msq_pkg::CASE_SADDLE5) || (cs == msq_pkg::CASE_SADDLE10);
    assign tr_first   = (cs == msq_pkg::CASE_SADDLE5) == (corner_sum >= thr4);
    assign pair       = msq_pkg::plain_pair(cs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.classify) begin
            r_two <= saddle;
            if (saddle && tr_first) begin
                r_edge[0] <= msq_pkg::EDGE_TOP;
                r_edge[1] <= msq_pkg::EDGE_RIGHT;
                r_edge[2] <= msq_pkg::EDGE_BOTTOM;
                r_edge[3] <= msq_pkg::EDGE_LEFT;
            end else if (saddle) begin
                r_edge[0] <= msq_pkg::EDGE_TOP;
                r_edge[1] <= msq_pkg::EDGE_LEFT;
                r_edge[2] <= msq_pkg::EDGE_RIGHT;
                r_edge[3] <= msq_pkg::EDGE_BOTTOM;
            end else begin
                r_edge[0] <= pair[2*EW-1:EW];
                r_edge[1] <= pair[EW-1:0];
                r_edge[2] <= pair[2*EW-1:EW];
                r_edge[3] <= pair[EW-1:0];
            end
        end
    end

    // crossing fraction setup
    logic [EW-1:0]        cur_edge;
    logic signed [DW-1:0] ca;
    logic signed [DW-1:0] cb;
    logic signed [DW-1:0] den;
    logic signed [DW-1:0] num;
    logic [DW-1:0]        un;
    logic [DW-1:0]        ud;
    logic                 direct;
    logic [FRAC_W-1:0]    direct_val;
    logic [FRAC_W-1:0]    r_frac [2];
    logic                 div_done;
    logic [FRACTION_BITS-1:0] quot;

    assign cur_edge = r_edge[i_cmd.slot];

    always_comb begin
        case (cur_edge)
            msq_pkg::EDGE_TOP: begin
                ca = cor_x[0];
                cb = cor_x[1];
            end
            msq_pkg::EDGE_RIGHT: begin
                ca = cor_x[1];
                cb = cor_x[2];
            end
            msq_pkg::EDGE_BOTTOM: begin
                ca = cor_x[3];
                cb = cor_x[2];
            end
            default: begin
                ca = cor_x[0];
                cb = cor_x[3];
            end
        endcase
    end

    assign den = cb - ca;
    assign num = thr_x - ca;
    assign un  = num[DW-1] ? DW'(-num) : DW'(num);
    assign ud  = den[DW-1] ? DW'(-den) : DW'(den);

    always_comb begin
        direct     = 1'b1;
        direct_val = '0;
        if (den == '0) begin
            direct_val = FRAC_HALF;
        end else if ((num == '0) || (num[DW-1] != den[DW-1])) begin
            direct_val = '0;
        end else if (un >= ud) begin
            direct_val = FRAC_ONE;
        end else begin
            direct = 1'b0;
        end
    end

    msq_div #(
        .NUM_W (DW),
        .Q_W   (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.prep && !direct),
        .i_num   (un),
        .i_den   (ud),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep && direct) begin
            r_frac[i_cmd.slot[0]] <= direct_val;
        end else if (i_cmd.store_q) begin
            r_frac[i_cmd.slot[0]] <= {1'b0, quot};
        end
    end

    // output register
    logic                        r_out_valid;
    logic [msq_pkg::COL_OUT_W-1:0] r_o_col;
    logic [ROW_W-1:0]            r_o_row;
    logic [EW-1:0]               r_o_e1;
    logic [EW-1:0]               r_o_e2;
    logic [FRAC_W-1:0]           r_o_f1;
    logic [FRAC_W-1:0]           r_o_f2;
    logic                        r_o_last;
    logic [31:0]                 cell_col_ext;

    assign cell_col_ext = 32'(r_cell_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_col  <= cell_col_ext[msq_pkg::COL_OUT_W-1:0];
            r_o_row  <= r_cell_row;
            r_o_e1   <= r_edge[{i_cmd.slot[1], 1'b0}];
            r_o_e2   <= r_edge[{i_cmd.slot[1], 1'b1}];
            r_o_f1   <= r_frac[0];
            r_o_f2   <= r_frac[1];
            r_o_last <= i_cmd.slot[1] || !r_two;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_column     = r_o_col;
    assign o_cell_row        = r_o_row;
    assign o_first_edge      = r_o_e1;
    assign o_first_fraction  = r_o_f1;
    assign o_second_edge     = r_o_e2;
    assign o_second_fraction = r_o_f2;
    assign o_last_of_cell    = r_o_last;

    assign o_sts.has_seg  = r_cell && (saddle || msq_pkg::is_plain(cs));
    assign o_sts.two_seg  = r_two;
    assign o_sts.direct   = direct;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== hw/rtl/msq_ctrl.sv =====
// msq_ctrl: controller state machine that sequences capture, classification,
// the two crossing fractions of each segment and segment output; uses msq_pkg

module msq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msq_pkg::t_sts i_sts,
    output msq_pkg::t_cmd o_cmd
);

    msq_pkg::t_state r_state;
    msq_pkg::t_state n_state;
    logic [1:0]      r_slot;
    logic [1:0]      n_slot;
    logic            frac_ready;

    assign frac_ready = (r_state == msq_pkg::S_PREP && i_sts.direct) ||
                        (r_state == msq_pkg::S_DIV && i_sts.div_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msq_pkg::S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        case (r_state)
            msq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = msq_pkg::S_READ;
                end
            end
            msq_pkg::S_READ: begin
                n_state = msq_pkg::S_CLASS;
            end
            msq_pkg::S_CLASS: begin
                n_slot  = '0;
                n_state = i_sts.has_seg ? msq_pkg::S_PREP : msq_pkg::S_IDLE;
            end
            msq_pkg::S_PREP, msq_pkg::S_DIV: begin
                if (frac_ready) begin
                    if (r_slot[0]) begin
                        n_state = msq_pkg::S_EMIT;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = msq_pkg::S_PREP;
                    end
                end else begin
                    n_state = msq_pkg::S_DIV;
                end
            end
            msq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_slot[1] || !i_sts.two_seg) begin
                        n_state = msq_pkg::S_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = msq_pkg::S_PREP;
                    end
                end
            end
            default: begin
                n_state = msq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.slot = r_slot;
        o_in_ready = 1'b0;
        case (r_state)
            msq_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            msq_pkg::S_READ: begin
                o_cmd.capture = 1'b1;
            end
            msq_pkg::S_CLASS: begin
                o_cmd.classify = 1'b1;
            end
            msq_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            msq_pkg::S_DIV: begin
                o_cmd.store_q = i_sts.div_done;
            end
            msq_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("segment loaded while output register busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == msq_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == msq_pkg::S_READ))
        else $error("accepted transaction not followed by store read");
`endif

endmodule

// ===== hw/rtl/marching_squares_cell_segments_top.sv =====
// marching_squares_cell_segments_top: top level of the marching squares cell segmenter
// depends on msq_pkg, msq_ctrl, msq_datapath and msq_div

// Samples enter in raster order, one transaction each; every sample from column 1 and row 1
// onward closes one cell and yields zero, one or two segment transactions. The block works on
// one sample at a time: each segment takes two crossing fractions from the shared radix-2
// divider, or without it where a fraction is a clamp or one half, and then a load of the
// output register, which waits while that register still holds a segment not yet taken.
// The previous row lives in a single-port store of MAX_COLUMNS entries; the next sample is
// taken while the last segment still waits at the output register.

module marching_squares_cell_segments_top #(
    parameter int MAX_COLUMNS   = 1024,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [msq_pkg::COL_OUT_W-1:0]  o_cell_column,
    output logic [msq_pkg::ROW_W-1:0]      o_cell_row,
    output logic [msq_pkg::EDGE_W-1:0]     o_first_edge,
    output logic [FRACTION_BITS:0]         o_first_fraction,
    output logic [msq_pkg::EDGE_W-1:0]     o_second_edge,
    output logic [FRACTION_BITS:0]         o_second_fraction,
    output logic                           o_last_of_cell
);

    msq_pkg::t_cmd cmd;
    msq_pkg::t_sts sts;

    msq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msq_datapath #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_cell_column     (o_cell_column),
        .o_cell_row        (o_cell_row),
        .o_first_edge      (o_first_edge),
        .o_first_fraction  (o_first_fraction),
        .o_second_edge     (o_second_edge),
        .o_second_fraction (o_second_fraction),
        .o_last_of_cell    (o_last_of_cell)
    );

endmodule
